// ===== hdl/least_served_task_scheduler_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef LEAST_SERVED_TASK_SCHEDULER_MACROS_SVH
`define LEAST_SERVED_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LSTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LSTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lsts_pkg.sv =====
// Shared types, codes and widths for the least-served task scheduler.
`timescale 1ns / 1ps
package lsts_pkg;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NUM_TASKS_DEF   = 64;

  localparam int OP_W    = 3;
  localparam int ID_W    = 6;
  localparam int NS_W    = 48;
  localparam int ST_W    = 3;
  localparam int CNT_W   = 5;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 32;
  localparam int SLICE_W = 10;
  localparam int SLEFT_W = 11;
  localparam int MARK_W  = 32;
  localparam int STAMP_W = 32;

  localparam logic [OP_W-1:0] OP_ENQ  = 3'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 3'd1;
  localparam logic [OP_W-1:0] OP_PICK = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK = 3'd3;
  localparam logic [OP_W-1:0] OP_BUMP = 3'd4;
  localparam logic [OP_W-1:0] OP_ACCT = 3'd5;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [ST_W-1:0] ST_THROTTLED = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND  = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

  localparam logic [CIDX_W-1:0] REG_SLICE  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_BUDGET = 2'd1;
  localparam logic [CIDX_W-1:0] REG_PERIOD = 2'd2;

  localparam logic [SLICE_W-1:0] SLICE_RST  = 10'd10;
  localparam logic [CDAT_W-1:0]  BUDGET_RST = 32'd950000000;
  localparam logic [CDAT_W-1:0]  PERIOD_RST = 32'd1000000000;

  typedef struct packed {
    logic [MARK_W-1:0]  marks;
    logic [STAMP_W-1:0] stamp;
  } task_word_t;
endpackage

// ===== hdl/lsts_in_if.sv =====
// Input channel: one scheduler operation per transfer.
`timescale 1ns / 1ps
interface lsts_in_if import lsts_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] opcode;
  logic [ID_W-1:0] task_id;
  logic [NS_W-1:0] now_ns;
  modport source (output valid, output opcode, output task_id, output now_ns, input ready);
  modport sink   (input valid, input opcode, input task_id, input now_ns, output ready);
endinterface

// ===== hdl/lsts_out_if.sv =====
// Result channel: one result per operation.
`timescale 1ns / 1ps
interface lsts_out_if import lsts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [ID_W-1:0]  picked_task;
  logic             resched;
  logic [CNT_W-1:0] queue_count;
  modport source (output valid, output status, output picked_task, output resched,
                  output queue_count, input ready);
  modport sink   (input valid, input status, input picked_task, input resched,
                  input queue_count, output ready);
endinterface

// ===== hdl/lsts_cfg_if.sv =====
// Configuration write channel.
`timescale 1ns / 1ps
interface lsts_cfg_if import lsts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/least_served_task_scheduler.sv =====
// Top level of the least-served task scheduler: control FSM and its two memories.
`timescale 1ns / 1ps
// Channel | dir | transfer when      | payload
// in_ch   | in  | valid && ready     | opcode, task_id, now_ns
// out_ch  | out | valid && ready     | status, picked_task, resched, queue_count
// cfg_ch  | in  | valid && ready     | index, data (always ready)
//
// Queue scans take one entry a cycle: bump and dequeue search for the task, pick reads every
// queued entry, and dequeue then shifts the tail one place toward the head.
// Synchronous reset clears the FSM, counters and mark valid bits at once; configuration returns to its defaults.
// A result waits in the output register; no new operation is taken until it goes.
module least_served_task_scheduler
  import lsts_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int NUM_TASKS   = NUM_TASKS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  lsts_in_if.sink    in_ch,
  lsts_out_if.source out_ch,
  lsts_cfg_if.sink   cfg_ch
);
`include "least_served_task_scheduler_macros.svh"

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int TIW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_ACC1    = 4'd2;
  localparam logic [3:0] S_ACC2    = 4'd3;
  localparam logic [3:0] S_POST    = 4'd4;
  localparam logic [3:0] S_PER     = 4'd5;
  localparam logic [3:0] S_PSCAN   = 4'd6;
  localparam logic [3:0] S_PCOMMIT = 4'd7;
  localparam logic [3:0] S_FIND    = 4'd8;
  localparam logic [3:0] S_SHIFT   = 4'd9;
  localparam logic [3:0] S_ENQ     = 4'd10;
  localparam logic [3:0] S_TRD     = 4'd11;
  localparam logic [3:0] S_TWR     = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  // Configuration
  logic [SLICE_W-1:0] slice_ticks_r;
  logic [CDAT_W-1:0]  budget_lim_r;
  logic [CDAT_W-1:0]  period_len_r;

  // Scheduler scalars
  logic [QCW-1:0]     len_r;
  logic [STAMP_W-1:0] tick_r;
  logic [NS_W-1:0]    budget_r;
  logic [NS_W-1:0]    pbegin_r;
  logic [ID_W-1:0]    run_task_r;
  logic               run_valid_r;
  logic [NS_W-1:0]    run_start_r;
  logic [SLEFT_W-1:0] slice_left_r;

  // Operation context
  logic [3:0]      state_r, state_nxt;
  logic [OP_W-1:0] op_r;
  logic [ID_W-1:0] id_r;
  logic [NS_W-1:0] now_r;
  logic [ID_W-1:0] tid_r;     // task memory target for read-modify-write
  logic            bump_r;    // RMW increments marks instead of stamping
  logic [ST_W-1:0] status_r;
  logic [ID_W-1:0] picked_r;
  logic            resched_r;
  logic [NS_W-1:0] delta_r;

  // Scan pipeline
  logic [QCW-1:0]     scan_r;
  logic               rv1_r, rv2_r;
  logic [QAW-1:0]     qa_d_r;
  logic [ID_W-1:0]    tid_d_r;
  logic               first_r;
  logic [ID_W-1:0]    best_id_r;
  logic [MARK_W-1:0]  best_mk_r;
  logic [STAMP_W-1:0] best_st_r;

  // Output register
  logic             out_valid_r;
  logic [ST_W-1:0]  o_status_r;
  logic [ID_W-1:0]  o_picked_r;
  logic             o_resched_r;
  logic [CNT_W-1:0] o_count_r;

  // Memories
  logic [ID_W-1:0]  qmem [QUEUE_DEPTH];
  logic [ID_W-1:0]  q_rdata_r;
  logic [ID_W-1:0]  q_wdata;
  logic [QAW-1:0]   q_raddr, q_waddr;
  logic             q_we;
  task_word_t       tmem [NUM_TASKS];
  task_word_t       t_rdata_r, t_wdata;
  logic             t_mv_r;
  logic [NUM_TASKS-1:0] mv_r;   // mark valid: clear entry reads as zero marks
  logic [TIW-1:0]   t_raddr, t_waddr;
  logic             t_we;

  // Datapath helpers
  logic [NS_W-1:0]   acc_delta;
  logic              acc_ok;
  logic              per_restart;
  logic [NS_W:0]     bsum;
  logic [NS_W-1:0]   bsat;
  logic              id_bad;
  logic              scan_more;
  logic [MARK_W-1:0] mark_eff;
  logic              better;
  logic [SLEFT_W-1:0] slice_dec;

  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = o_status_r;
  assign out_ch.picked_task = o_picked_r;
  assign out_ch.resched     = o_resched_r;
  assign out_ch.queue_count = o_count_r;

  assign acc_delta   = now_r - run_start_r;
  assign acc_ok      = run_valid_r && (acc_delta != '0) && !acc_delta[NS_W-1];
  assign per_restart = (pbegin_r == '0) ||
                       ((now_r - pbegin_r) >= {{(NS_W-CDAT_W){1'b0}}, period_len_r});
  assign bsum        = {1'b0, budget_r} + {1'b0, delta_r};
  assign bsat        = bsum[NS_W] ? {NS_W{1'b1}} : bsum[NS_W-1:0];
  assign id_bad      = (32'(id_r) >= 32'(NUM_TASKS));
  assign scan_more   = (scan_r < len_r);
  assign mark_eff    = t_mv_r ? t_rdata_r.marks : '0;
  assign better      = first_r || (mark_eff < best_mk_r) ||
                       ((mark_eff == best_mk_r) && (t_rdata_r.stamp < best_st_r));
  assign slice_dec   = (slice_left_r != '0) ? slice_left_r - 1'b1 : '0;

  // Memory strobes
  always_comb begin
    q_raddr = scan_r[QAW-1:0];
    q_we    = 1'b0;
    q_waddr = len_r[QAW-1:0];
    q_wdata = id_r;
    if (state_r == S_ENQ) begin
      q_we = 1'b1;
    end else if (state_r == S_SHIFT && rv1_r) begin
      q_we    = 1'b1;
      q_waddr = qa_d_r - 1'b1;   // move entry one place toward the head
      q_wdata = q_rdata_r;
    end
    t_raddr = (state_r == S_PSCAN) ? TIW'(q_rdata_r) : TIW'(tid_r);
    t_we    = (state_r == S_TWR) || (state_r == S_PCOMMIT);
    t_waddr = (state_r == S_PCOMMIT) ? TIW'(best_id_r) : TIW'(tid_r);
    if (state_r == S_PCOMMIT) begin
      t_wdata = '{marks: best_mk_r, stamp: tick_r};
    end else if (bump_r) begin
      t_wdata = '{marks: (mark_eff == {MARK_W{1'b1}}) ? mark_eff : mark_eff + 1'b1,
                  stamp: t_rdata_r.stamp};
    end else begin
      t_wdata = '{marks: mark_eff, stamp: tick_r};
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_waddr] <= q_wdata;
    end
    q_rdata_r <= qmem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[t_waddr] <= t_wdata;
    end
    t_rdata_r <= tmem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r   <= '0;
      t_mv_r <= 1'b0;
    end else begin
      if (t_we) begin
        mv_r[t_waddr] <= 1'b1;
      end
      t_mv_r <= mv_r[t_raddr];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_ch.valid && in_ch.ready) state_nxt = S_DISP;
      S_DISP: begin
        unique case (op_r)
          OP_ENQ:  state_nxt = (id_bad || len_r >= QCW'(QUEUE_DEPTH)) ? S_DONE : S_ENQ;
          OP_DEQ,
          OP_TICK,
          OP_ACCT: state_nxt = S_ACC1;
          OP_PICK: state_nxt = (len_r == '0) ? S_DONE : S_PER;
          OP_BUMP: state_nxt = id_bad ? S_DONE : S_FIND;
          default: state_nxt = S_DONE;
        endcase
      end
      S_ACC1:    state_nxt = acc_ok ? S_ACC2 : S_POST;
      S_ACC2:    state_nxt = S_POST;
      S_POST: begin
        if (op_r == OP_DEQ) begin
          state_nxt = (len_r == '0 || id_bad) ? S_DONE : S_FIND;
        end else if (op_r == OP_TICK && run_valid_r) begin
          state_nxt = S_TRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PER: begin
        if (per_restart ? (budget_lim_r == '0)
                        : (budget_r >= {{(NS_W-CDAT_W){1'b0}}, budget_lim_r})) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_PSCAN;
        end
      end
      S_PSCAN:   if (!scan_more && !rv1_r && !rv2_r) state_nxt = S_PCOMMIT;
      S_PCOMMIT: state_nxt = S_DONE;
      S_FIND: begin
        if (rv1_r && q_rdata_r == id_r) begin
          state_nxt = (op_r == OP_DEQ) ? S_SHIFT : S_TRD;
        end else if (!scan_more && !rv1_r) begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT:   if (!scan_more && !rv1_r) state_nxt = S_DONE;
      S_ENQ:     state_nxt = S_TRD;
      S_TRD:     state_nxt = S_TWR;
      S_TWR:     state_nxt = S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      slice_ticks_r <= SLICE_RST;
      budget_lim_r  <= BUDGET_RST;
      period_len_r  <= PERIOD_RST;
      len_r         <= '0;
      tick_r        <= '0;
      budget_r      <= '0;
      pbegin_r      <= '0;
      run_task_r    <= '0;
      run_valid_r   <= 1'b0;
      run_start_r   <= '0;
      slice_left_r  <= '0;
      out_valid_r   <= 1'b0;
      rv1_r         <= 1'b0;
      rv2_r         <= 1'b0;
      scan_r        <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_SLICE:  slice_ticks_r <= cfg_ch.data[SLICE_W-1:0];
          REG_BUDGET: budget_lim_r  <= cfg_ch.data;
          REG_PERIOD: period_len_r  <= cfg_ch.data;
          default: ;
        endcase
      end

      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            op_r      <= in_ch.opcode;
            id_r      <= in_ch.task_id;
            now_r     <= in_ch.now_ns;
            tid_r     <= in_ch.task_id;
            status_r  <= ST_OK;
            picked_r  <= '0;
            resched_r <= 1'b0;
            bump_r    <= (in_ch.opcode == OP_BUMP);
          end
        end
        S_DISP: begin
          scan_r <= '0;
          rv1_r  <= 1'b0;
          rv2_r  <= 1'b0;
          if (op_r == OP_ENQ) begin
            if (id_bad) begin
              status_r <= ST_NOTFOUND;
            end else if (len_r >= QCW'(QUEUE_DEPTH)) begin
              status_r <= ST_FULL;
            end
          end else if (op_r == OP_PICK && len_r == '0) begin
            status_r <= ST_EMPTY;
          end else if (op_r == OP_BUMP && id_bad) begin
            status_r <= ST_NOTFOUND;
          end
        end
        S_ACC1: begin
          if (acc_ok) begin
            run_start_r <= now_r;
            delta_r     <= acc_delta;
            if (per_restart) begin
              pbegin_r <= now_r;
              budget_r <= '0;
            end
          end
        end
        S_ACC2: begin
          budget_r <= bsat;
          if (bsat >= {{(NS_W-CDAT_W){1'b0}}, budget_lim_r}) begin
            resched_r <= 1'b1;
          end
        end
        S_POST: begin
          if (op_r == OP_DEQ) begin
            if (len_r == '0) begin
              status_r <= ST_EMPTY;
            end else if (id_bad) begin
              status_r <= ST_NOTFOUND;
            end
          end else if (op_r == OP_TICK) begin
            tick_r <= tick_r + 1'b1;
            if (run_valid_r) begin
              slice_left_r <= slice_dec;
              tid_r        <= run_task_r;
              if (slice_dec == '0) begin
                resched_r <= 1'b1;
              end
            end
          end
        end
        S_PER: begin
          first_r <= 1'b1;
          if (per_restart) begin
            pbegin_r <= now_r;
            budget_r <= '0;
          end
          if (per_restart ? (budget_lim_r == '0)
                          : (budget_r >= {{(NS_W-CDAT_W){1'b0}}, budget_lim_r})) begin
            status_r  <= ST_THROTTLED;
            resched_r <= 1'b1;
          end
        end
        S_PSCAN: begin
          // queue read -> task read -> compare
          if (scan_more) begin
            scan_r <= scan_r + 1'b1;
          end
          rv1_r   <= scan_more;
          rv2_r   <= rv1_r;
          tid_d_r <= q_rdata_r;
          if (rv2_r && better) begin
            first_r   <= 1'b0;
            best_id_r <= tid_d_r;
            best_mk_r <= mark_eff;
            best_st_r <= t_rdata_r.stamp;
          end
        end
        S_PCOMMIT: begin
          slice_left_r <= SLEFT_W'(slice_ticks_r);
          run_task_r   <= best_id_r;
          run_valid_r  <= 1'b1;
          run_start_r  <= now_r;
          picked_r     <= best_id_r;
        end
        S_FIND: begin
          if (rv1_r && q_rdata_r == id_r) begin
            // hit: dequeue shifts from the next entry, bump goes to RMW
            scan_r <= QCW'(qa_d_r) + 1'b1;
            rv1_r  <= 1'b0;
          end else begin
            if (scan_more) begin
              scan_r <= scan_r + 1'b1;
            end
            rv1_r  <= scan_more;
            qa_d_r <= scan_r[QAW-1:0];
            if (!scan_more && !rv1_r) begin
              status_r <= ST_NOTFOUND;
            end
          end
        end
        S_SHIFT: begin
          if (scan_more) begin
            scan_r <= scan_r + 1'b1;
          end
          rv1_r  <= scan_more;
          qa_d_r <= scan_r[QAW-1:0];
          if (!scan_more && !rv1_r) begin
            len_r <= len_r - 1'b1;
          end
        end
        S_ENQ: begin
          len_r <= len_r + 1'b1;
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          o_status_r  <= status_r;
          o_picked_r  <= picked_r;
          o_resched_r <= resched_r;
          o_count_r   <= CNT_W'(len_r);
        end
        default: ;
      endcase
    end
  end

  `LSTS_ASSERT_NOW(a_len_bound, 1'b1, len_r <= QCW'(QUEUE_DEPTH), "queue length over depth")
  `LSTS_ASSERT_NEXT(a_done_out, state_r == S_DONE, out_valid_r && state_r == S_IDLE, "no result")
  `LSTS_ASSERT_NEXT(a_pick_runs, state_r == S_PCOMMIT, run_valid_r && run_task_r == picked_r, "no run")
  `LSTS_ASSERT_NOW(a_busy_no_take, state_r != S_IDLE, !in_ch.ready, "input taken while busy")

endmodule

// ===== verif/lsts_checker.sv =====
// Scheduler checker: watches the channels, predicts each result and compares it.
`timescale 1ns / 1ps
module lsts_checker
  import lsts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lsts_in_if   in_ch,
  lsts_out_if  out_ch,
  lsts_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);
  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int TASKS = NUM_TASKS_DEF;

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [ID_W-1:0]  picked;
    logic             resched;
    logic [CNT_W-1:0] count;
  } sched_result_t;

  sched_result_t expected_results[$];

  logic [SLICE_W-1:0] slice_cfg;
  logic [CDAT_W-1:0]  budget_cfg;
  logic [CDAT_W-1:0]  period_cfg;

  logic [ID_W-1:0]    run_queue[DEPTH];
  int unsigned        run_len;
  logic [MARK_W-1:0]  marks[TASKS];
  logic [STAMP_W-1:0] served_at[TASKS];
  logic [31:0]        tick_now;
  logic [NS_W-1:0]    used_ns;
  logic [NS_W-1:0]    period_origin;
  logic [ID_W-1:0]    cur_task;
  bit                 cur_valid;
  logic [NS_W-1:0]    cur_start;
  int unsigned        slice_rem;

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void roll_period(input logic [NS_W-1:0] now);
    logic [NS_W-1:0] age;
    age = now - period_origin;
    if (period_origin == '0 || age >= {16'b0, period_cfg}) begin
      period_origin = now;
      used_ns = '0;
    end
  endfunction

  // charge run time of the running task; returns 1 when the budget is spent
  function automatic bit charge_runtime(input logic [NS_W-1:0] now);
    logic [NS_W-1:0] delta;
    logic [NS_W:0]   sum;
    if (!cur_valid) return 1'b0;
    delta = now - cur_start;
    if (delta == '0 || delta[NS_W-1]) return 1'b0;
    cur_start = now;
    roll_period(now);
    sum = {1'b0, used_ns} + {1'b0, delta};
    used_ns = sum[NS_W] ? '1 : sum[NS_W-1:0];
    return used_ns >= {16'b0, budget_cfg};
  endfunction

  function automatic int find_task(input logic [ID_W-1:0] id);
    for (int i = 0; i < run_len; i++)
      if (run_queue[i] == id) return i;
    return -1;
  endfunction

  function automatic sched_result_t predict_sched(input logic [OP_W-1:0] op,
                                                  input logic [ID_W-1:0] id,
                                                  input logic [NS_W-1:0] now);
    sched_result_t r;
    int pos;
    logic [ID_W-1:0] best;
    r = '{ST_OK, '0, 1'b0, '0};
    case (op)
      OP_ENQ: begin
        if (run_len >= DEPTH) r.status = ST_FULL;
        else begin
          served_at[id] = tick_now;
          run_queue[run_len] = id;
          run_len++;
        end
      end
      OP_DEQ: begin
        r.resched = charge_runtime(now);
        if (run_len == 0) r.status = ST_EMPTY;
        else begin
          pos = find_task(id);
          if (pos < 0) r.status = ST_NOTFOUND;
          else begin
            for (int i = pos; i + 1 < run_len; i++) run_queue[i] = run_queue[i+1];
            run_len--;
          end
        end
      end
      OP_PICK: begin
        if (run_len == 0) r.status = ST_EMPTY;
        else begin
          roll_period(now);
          if (used_ns >= {16'b0, budget_cfg}) begin
            r.status = ST_THROTTLED;
            r.resched = 1'b1;
          end else begin
            best = run_queue[0];
            // fewest marks wins, then oldest stamp, then queue order
            for (int i = 1; i < run_len; i++)
              if (marks[run_queue[i]] < marks[best] ||
                  (marks[run_queue[i]] == marks[best] &&
                   served_at[run_queue[i]] < served_at[best]))
                best = run_queue[i];
            served_at[best] = tick_now;
            slice_rem = slice_cfg;
            cur_task = best;
            cur_valid = 1'b1;
            cur_start = now;
            r.picked = best;
          end
        end
      end
      OP_TICK: begin
        r.resched = charge_runtime(now);
        tick_now++;
        if (cur_valid) begin
          served_at[cur_task] = tick_now;
          if (slice_rem > 0) slice_rem--;
          if (slice_rem == 0) r.resched = 1'b1;
        end
      end
      OP_BUMP: begin
        if (find_task(id) < 0) r.status = ST_NOTFOUND;
        else if (marks[id] != '1) marks[id]++;
      end
      OP_ACCT: r.resched = charge_runtime(now);
      default: ;
    endcase
    r.count = run_len[CNT_W-1:0];
    return r;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    sched_result_t want;
    if (!rst_n) begin
      slice_cfg = SLICE_RST;
      budget_cfg = BUDGET_RST;
      period_cfg = PERIOD_RST;
      run_len = 0;
      foreach (marks[i]) marks[i] = '0;
      foreach (served_at[i]) served_at[i] = '0;
      tick_now = '0;
      used_ns = '0;
      period_origin = '0;
      cur_task = '0;
      cur_valid = 1'b0;
      cur_start = '0;
      slice_rem = 0;
      expected_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_SLICE:  slice_cfg = cfg_ch.data[SLICE_W-1:0];
          REG_BUDGET: budget_cfg = cfg_ch.data;
          REG_PERIOD: period_cfg = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(predict_sched(in_ch.opcode, in_ch.task_id, in_ch.now_ns));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", out_ch.status, -1);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status) report("status", out_ch.status, want.status);
          if (out_ch.picked_task !== want.picked)
            report("picked_task", out_ch.picked_task, want.picked);
          if (out_ch.resched !== want.resched) report("resched", out_ch.resched, want.resched);
          if (out_ch.queue_count !== want.count)
            report("queue_count", out_ch.queue_count, want.count);
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

// ===== verif/testbench.sv =====
// Testbench top: clock, reset, stimulus for the scheduler and the final verdict.
`timescale 1ns / 1ps
module testbench;
  import lsts_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASES      = 8;
  localparam int PHASE_OPS   = 75;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles = 0;

  // idling controls in percent of cycles, changed per phase
  int   idle_pct;
  int   stall_pct;

  // running task clock used for now_ns
  logic [NS_W-1:0] clock_ns;

  lsts_in_if  in_ch();
  lsts_out_if out_ch();
  lsts_cfg_if cfg_ch();

  least_served_task_scheduler dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  lsts_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // result side back-pressure at the phase's stall rate
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // run guard: a hang or a lost result ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // one operation transfer; valid stays up into the next call unless a gap comes
  task automatic send_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                         input logic [NS_W-1:0] now);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.task_id <= id;
    in_ch.now_ns  <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // lower valid and wait until every expected result has come back
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // next clock value: mostly small forward steps, sometimes big jumps,
  // repeats, steps backward and wild values
  function automatic logic [NS_W-1:0] next_now();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) clock_ns = clock_ns + NS_W'($urandom_range(2000, 1));
    else if (sel < 75) clock_ns = clock_ns + NS_W'({$urandom_range(3), $urandom()});
    else if (sel < 82) clock_ns = clock_ns;
    else if (sel < 90) clock_ns = clock_ns - NS_W'($urandom_range(500, 1));
    else if (sel < 95) clock_ns = clock_ns + {$urandom(), 16'h0};
    else clock_ns = NS_W'({$urandom(), $urandom()});
    return clock_ns;
  endfunction

  // task ids drawn mostly from a small pool so dequeue and bump find them
  function automatic logic [ID_W-1:0] pick_id();
    return ID_W'(($urandom_range(99) < 75) ? $urandom_range(7) : $urandom_range(63));
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int w;
    w = $urandom_range(99);
    if (w < 25) return OP_ENQ;
    if (w < 40) return OP_DEQ;
    if (w < 60) return OP_PICK;
    if (w < 78) return OP_TICK;
    if (w < 88) return OP_BUMP;
    if (w < 96) return OP_ACCT;
    return OP_W'($urandom_range(7, 6));
  endfunction

  // register settings per phase: slice, budget, period
  logic [CDAT_W-1:0] slice_set[PHASES]  = '{10, 0, 1000, 3, 1, 1000, 0, 7};
  logic [CDAT_W-1:0] budget_set[PHASES] = '{950000000, 0, 32'hFFFF_FFFF, 5000,
                                            200, 32'hFFFF_FFFF, 1, 40000};
  logic [CDAT_W-1:0] period_set[PHASES] = '{1000000000, 1, 32'hFFFF_FFFF, 1000000,
                                            32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 3000};

  initial begin
    rst_n           = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    clock_ns        = 48'd1;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_ENQ;
    in_ch.task_id   = '0;
    in_ch.now_ns    = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_SLICE;
    cfg_ch.data     = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queue, no running task, id extremes, duplicates,
    // zero and backward time steps, unused opcodes, full queue
    send_op(OP_PICK, 6'd0, 48'd10);
    send_op(OP_DEQ, 6'd0, 48'd10);
    send_op(OP_TICK, 6'd0, 48'd10);
    send_op(OP_ACCT, 6'd0, 48'd10);
    send_op(OP_ENQ, 6'd63, 48'd20);
    send_op(OP_ENQ, 6'd0, 48'd20);
    send_op(OP_ENQ, 6'd63, 48'd20);
    send_op(OP_BUMP, 6'd63, 48'd20);
    send_op(OP_BUMP, 6'd5, 48'd20);
    send_op(OP_PICK, 6'd0, 48'd100);
    send_op(OP_TICK, 6'd0, 48'd100);
    send_op(OP_TICK, 6'd0, 48'd50);
    send_op(OP_ACCT, 6'd0, 48'hFFFF_FFFF_FFFF);
    send_op(OP_ACCT, 6'd0, 48'd1000);
    send_op(OP_DEQ, 6'd5, 48'd1100);
    send_op(OP_DEQ, 6'd63, 48'd1200);
    send_op(3'd6, 6'd42, 48'd1300);
    send_op(3'd7, 6'd21, 48'd1300);
    for (int i = 0; i < 15; i++) send_op(OP_ENQ, 6'(i * 4 + 1), 48'd1400);
    send_op(OP_PICK, 6'd0, 48'd1500);
    drain();
    clock_ns = 48'd1600;

    // random phases: each with its own register setting and idling style
    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(REG_SLICE, slice_set[ph]);
      write_reg(REG_BUDGET, budget_set[ph]);
      write_reg(REG_PERIOD, period_set[ph]);
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 83; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 83; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      for (int n = 0; n < PHASE_OPS; n++) begin
        send_op(pick_op(), pick_id(), next_now());
      end
      drain();
    end

    idle_pct  = 0;
    stall_pct = 0;
    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
